@@ design/counting_sort_small_range_top_assert.svh @@
// Assertion macros shared by the counting sort modules.
// The asserting module must have aclk and aresetn in scope.
`ifndef COUNTING_SORT_SMALL_RANGE_TOP_ASSERT_SVH
`define COUNTING_SORT_SMALL_RANGE_TOP_ASSERT_SVH

// Same-cycle implication.
`define CSORT_CHECK(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csort check failed");

// Next-cycle implication.
`define CSORT_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csort check failed");

`endif

@@ design/csort_pkg.sv @@
`timescale 1ns / 1ps

package csort_pkg;

    // Field widths
    localparam int VAL_W       = 4;
    localparam int CNT_W       = 7;
    localparam int VEXT_W      = 9;
    localparam int TDATA_W     = 8;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified input word
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             in_range;
        logic             last;
    } csort_item_t;

    // Result word
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             dropped;
    } csort_result_t;

endpackage

@@ design/csort_ram.sv @@
`timescale 1ns / 1ps

module csort_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 10
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, registered read port (read returns the old word on collision)
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/csort_front.sv @@
`timescale 1ns / 1ps

module csort_front #(
    parameter int VALUE_RANGE = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [csort_pkg::VAL_W-1:0] item_value,
    input  logic                        end_of_set,
    output logic                        push_vld,
    input  logic                        push_rdy,
    output csort_pkg::csort_item_t      push_item
);

    import csort_pkg::*;

    logic        f_vld_reg;
    logic        f_vld_next;
    csort_item_t f_item_reg;
    logic [VEXT_W-1:0] val_ext;

    assign val_ext  = VEXT_W'(item_value);
    assign s_tready = !f_vld_reg || push_rdy;
    assign push_vld = f_vld_reg;
    assign push_item = f_item_reg;

    // Hold a word until the queue takes it
    always_comb begin
        f_vld_next = f_vld_reg;
        if (push_rdy) begin
            f_vld_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            f_vld_next = 1'b1;
        end
    end

    // Classify the value against the histogram range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else begin
            f_vld_reg <= f_vld_next;
        end
        if (s_tvalid && s_tready) begin
            f_item_reg.value    <= item_value;
            f_item_reg.in_range <= (val_ext < VEXT_W'(VALUE_RANGE));
            f_item_reg.last     <= end_of_set;
        end
    end

endmodule

@@ design/csort_queue.sv @@
`timescale 1ns / 1ps

`include "counting_sort_small_range_top_assert.svh"

module csort_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_vld,
    output logic                   push_rdy,
    input  csort_pkg::csort_item_t push_item,
    output logic                   pop_vld,
    input  logic                   pop,
    output csort_pkg::csort_item_t pop_item
);

    import csort_pkg::*;

    csort_item_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign push_rdy = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_vld  = (cnt_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];
    assign do_push  = push_vld && push_rdy;
    assign do_pop   = pop && pop_vld;

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= QCNT_W'(cnt_reg + 1'b1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= QCNT_W'(cnt_reg - 1'b1);
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `CSORT_CHECK(a_q_bound, 1'b1, cnt_reg <= QCNT_W'(QUEUE_DEPTH))
    `CSORT_CHECK_NEXT(a_q_full_hold, (cnt_reg == QCNT_W'(QUEUE_DEPTH)) && !pop, cnt_reg == QCNT_W'(QUEUE_DEPTH))

endmodule

@@ design/csort_back.sv @@
`timescale 1ns / 1ps

`include "counting_sort_small_range_top_assert.svh"

module csort_back #(
    parameter int VALUE_RANGE = 10,
    parameter int MAX_ITEMS   = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_vld,
    output logic                     q_pop,
    input  csort_pkg::csort_item_t   q_item,
    output logic                     res_vld,
    input  logic                     res_rdy,
    output csort_pkg::csort_result_t res
);

    import csort_pkg::*;

    localparam int BIN_AW = $clog2(VALUE_RANGE);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_RD,
        ST_CNT,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [VALUE_RANGE-1:0] bin_vld_reg, bin_vld_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic               ovf_reg, ovf_next;
    logic               b_vld_reg, b_vld_next;
    logic [BIN_AW-1:0]  rd_addr_reg, rd_addr_next;
    logic               lw_vld_reg, lw_vld_next;
    logic [BIN_AW-1:0]  lw_addr_reg, lw_addr_next;
    logic [CNT_W-1:0]   lw_data_reg, lw_data_next;
    logic [BIN_AW-1:0]  bin_idx_reg, bin_idx_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic [CNT_W-1:0]   emit_cnt_reg, emit_cnt_next;
    logic               res_vld_reg, res_vld_next;
    csort_result_t      res_reg, res_next;

    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [BIN_AW-1:0]  ram_rd_addr;
    logic [CNT_W-1:0]   ram_rd_data;
    logic [CNT_W-1:0]   cnt_sel;
    logic [CNT_W-1:0]   cnt_inc;
    logic [VEXT_W-1:0]  q_val_ext;
    logic [VEXT_W-1:0]  bin_ext;
    logic               is_last;

    assign res_vld   = res_vld_reg;
    assign res       = res_reg;
    assign q_val_ext = VEXT_W'(q_item.value);
    assign bin_ext   = VEXT_W'(bin_idx_reg);
    assign is_last   = (CNT_W'(emit_cnt_reg + 1'b1) == held_reg);

    // Count of the bin just read: forward the latest write, unwritten bins read zero
    always_comb begin
        if (lw_vld_reg && (lw_addr_reg == rd_addr_reg)) begin
            cnt_sel = lw_data_reg;
        end else if (bin_vld_reg[rd_addr_reg]) begin
            cnt_sel = ram_rd_data;
        end else begin
            cnt_sel = '0;
        end
    end
    assign cnt_inc = CNT_W'(cnt_sel + 1'b1);

    csort_ram #(
        .WIDTH(CNT_W),
        .DEPTH(VALUE_RANGE)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (rd_addr_reg),
        .wr_data (cnt_inc),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        bin_vld_next  = bin_vld_reg;
        held_next     = held_reg;
        ovf_next      = ovf_reg;
        b_vld_next    = 1'b0;
        rd_addr_next  = rd_addr_reg;
        lw_vld_next   = lw_vld_reg;
        lw_addr_next  = lw_addr_reg;
        lw_data_next  = lw_data_reg;
        bin_idx_next  = bin_idx_reg;
        remain_next   = remain_reg;
        emit_cnt_next = emit_cnt_reg;
        res_vld_next  = res_vld_reg;
        res_next      = res_reg;
        ram_wr_en     = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = bin_idx_reg;
        q_pop         = 1'b0;

        // Drop the result once taken
        if (res_vld_reg && res_rdy) begin
            res_vld_next = 1'b0;
        end

        // Write back the incremented bin
        if (b_vld_reg) begin
            ram_wr_en                 = 1'b1;
            bin_vld_next[rd_addr_reg] = 1'b1;
            lw_vld_next               = 1'b1;
            lw_addr_next              = rd_addr_reg;
            lw_data_next              = cnt_inc;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (q_vld) begin
                    q_pop = 1'b1;
                    if (q_item.in_range && (held_reg < CNT_W'(MAX_ITEMS))) begin
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = q_val_ext[BIN_AW-1:0];
                        rd_addr_next = q_val_ext[BIN_AW-1:0];
                        b_vld_next   = 1'b1;
                        held_next    = CNT_W'(held_reg + 1'b1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (q_item.last) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                bin_idx_next  = '0;
                emit_cnt_next = '0;
                if (held_reg == '0) begin
                    bin_vld_next = '0;
                    lw_vld_next  = 1'b0;
                    ovf_next     = 1'b0;
                    state_next   = ST_LOAD;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                ram_rd_en    = 1'b1;
                rd_addr_next = bin_idx_reg;
                state_next   = ST_CNT;
            end
            ST_CNT: begin
                if (cnt_sel != '0) begin
                    remain_next = cnt_sel;
                    state_next  = ST_EMIT;
                end else if (bin_idx_reg == BIN_AW'(VALUE_RANGE - 1)) begin
                    bin_vld_next = '0;
                    lw_vld_next  = 1'b0;
                    held_next    = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_LOAD;
                end else begin
                    bin_idx_next = BIN_AW'(bin_idx_reg + 1'b1);
                    state_next   = ST_RD;
                end
            end
            ST_EMIT: begin
                if (!res_vld_reg || res_rdy) begin
                    res_vld_next     = 1'b1;
                    res_next.value   = bin_ext[VAL_W-1:0];
                    res_next.last    = is_last;
                    res_next.dropped = ovf_reg;
                    emit_cnt_next    = CNT_W'(emit_cnt_reg + 1'b1);
                    remain_next      = CNT_W'(remain_reg - 1'b1);
                    if (is_last) begin
                        bin_vld_next = '0;
                        lw_vld_next  = 1'b0;
                        held_next    = '0;
                        ovf_next     = 1'b0;
                        state_next   = ST_LOAD;
                    end else if (remain_reg == CNT_W'(1)) begin
                        bin_idx_next = BIN_AW'(bin_idx_reg + 1'b1);
                        state_next   = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State, histogram bookkeeping and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            bin_vld_reg <= '0;
            held_reg    <= '0;
            ovf_reg     <= 1'b0;
            b_vld_reg   <= 1'b0;
            lw_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bin_vld_reg <= bin_vld_next;
            held_reg    <= held_next;
            ovf_reg     <= ovf_next;
            b_vld_reg   <= b_vld_next;
            lw_vld_reg  <= lw_vld_next;
            res_vld_reg <= res_vld_next;
        end
        rd_addr_reg  <= rd_addr_next;
        lw_addr_reg  <= lw_addr_next;
        lw_data_reg  <= lw_data_next;
        bin_idx_reg  <= bin_idx_next;
        remain_reg   <= remain_next;
        emit_cnt_reg <= emit_cnt_next;
        res_reg      <= res_next;
    end

    `CSORT_CHECK(a_held_bound, 1'b1, held_reg <= CNT_W'(MAX_ITEMS))
    `CSORT_CHECK(a_emit_below_held, state_reg == ST_EMIT, emit_cnt_reg < held_reg)
    `CSORT_CHECK(a_wb_in_load, b_vld_reg, (state_reg == ST_LOAD) || (state_reg == ST_FLUSH))

endmodule

@@ design/counting_sort_small_range_top.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Ports                     Contents
// input    in   s_tvalid/s_tready/s_tdata  s_tdata[3:0] item_value, s_tlast end_of_set
// result   out  m_tvalid/m_tready/m_tdata  m_tdata[3:0] sorted_value, m_tlast last_of_run,
//                                          m_tuser dropped_flag
//
// Loading takes one value per cycle while the histogram loads; a four-word queue
// sits between the input stage and the histogram. After the end-of-set word: a
// flush state, then per bin visited a histogram RAM read and a count check, plus
// an emit per value emitted, all bound by the single histogram RAM read port.
// Reset is synchronous, active low; it clears the histogram valid bits at once.
// Input is taken while a result waits in the output register; m_tready low
// stalls the drain, and the input stalls once the queue has filled.

module counting_sort_small_range_top #(
    parameter int VALUE_RANGE = 10,
    parameter int MAX_ITEMS   = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [3:0] item_value, [7:4] zero
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] sorted_value, [7:4] zero
    output logic       m_tlast,
    output logic       m_tuser    // [0] dropped_flag
);

    import csort_pkg::*;

    logic          push_vld;
    logic          push_rdy;
    csort_item_t   push_item;
    logic          q_vld;
    logic          q_pop;
    csort_item_t   q_item;
    csort_result_t res;

    csort_front #(
        .VALUE_RANGE(VALUE_RANGE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .item_value (s_tdata[VAL_W-1:0]),
        .end_of_set (s_tlast),
        .push_vld   (push_vld),
        .push_rdy   (push_rdy),
        .push_item  (push_item)
    );

    csort_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_vld  (push_vld),
        .push_rdy  (push_rdy),
        .push_item (push_item),
        .pop_vld   (q_vld),
        .pop       (q_pop),
        .pop_item  (q_item)
    );

    csort_back #(
        .VALUE_RANGE(VALUE_RANGE),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_vld   (q_vld),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .res_vld (m_tvalid),
        .res_rdy (m_tready),
        .res     (res)
    );

    assign m_tdata = {(TDATA_W - VAL_W)'(0), res.value};
    assign m_tlast = res.last;
    assign m_tuser = res.dropped;

endmodule
